// ----- design/twg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twg_pkg
// Shared types and constants of the ternary weight matrix-vector block.
// ----------------------------------------------------------------------------
package twg_pkg;

    localparam int LANES    = 8;    // activations per transfer
    localparam int MAX_ROWS = 4;    // result fields per transfer
    localparam int ACT_W    = 8;
    localparam int TERM_W   = ACT_W + 1;  // negated -128 needs one more bit
    localparam int RES_W    = 15;
    localparam int MASK_W   = 64;
    localparam int MASK_IW  = $clog2(MASK_W);
    localparam int ELEM_W   = MASK_IW + 1;
    localparam int CFG_DW   = 64;
    localparam int CFG_AW   = $clog2(2 * MAX_ROWS) + 3;

    // Low bit of the register index picks the negative mask of a row
    localparam int REG_SEL_NEG = 0;

    typedef logic signed [ACT_W-1:0]  act_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [RES_W-1:0]  res_t;
    typedef logic [MASK_W-1:0]        mask_t;

    // Handoff from the lane stage to the merge stage
    typedef struct packed {
        logic fire;     // lane stage hands its terms on this cycle
        logic last;     // terms belong to the final chunk of a vector
    } twg_ctl_t;

endpackage
`default_nettype wire

// ----- design/twg_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twg_lane
// One activation lane: turns an activation and its ternary weight bits into
// a registered signed term for every row.
// ----------------------------------------------------------------------------
module twg_lane
    import twg_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                load,
    input  wire act_t                act,
    input  wire logic [MAX_ROWS-1:0] pos_bits,
    input  wire logic [MAX_ROWS-1:0] neg_bits,
    output term_t                    term_reg [MAX_ROWS]
);

    term_t term_next [MAX_ROWS];
    term_t act_ext;

    assign act_ext = TERM_W'(act);

    always_comb begin
        for (int r = 0; r < MAX_ROWS; r++) begin
            // both bits set reads as a zero weight
            if (pos_bits[r] && !neg_bits[r]) begin
                term_next[r] = act_ext;
            end else if (neg_bits[r] && !pos_bits[r]) begin
                term_next[r] = -act_ext;
            end else begin
                term_next[r] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            term_reg <= term_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/twg_merge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twg_merge
// Sums the lane terms of every row below ROW_COUNT into its accumulator and, on the final
// chunk, moves the row sums into the output register; other rows read zero.
// ----------------------------------------------------------------------------
module twg_merge
    import twg_pkg::*;
#(
    parameter int ROW_COUNT = 4
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire twg_ctl_t ctl,
    input  wire term_t    terms [LANES][MAX_ROWS],
    input  wire logic     out_ready,
    output logic          out_valid,
    output res_t          result [MAX_ROWS]
);

    logic out_valid_reg;
    logic out_valid_next;

    assign out_valid = out_valid_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctl.fire && ctl.last) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
        if (r < ROW_COUNT) begin : g_live
            res_t acc_reg;
            res_t acc_next;
            res_t sum;
            res_t res_reg;

            always_comb begin
                sum = acc_reg;
                for (int l = 0; l < LANES; l++) begin
                    sum = sum + RES_W'(terms[l][r]);
                end
                acc_next = acc_reg;
                if (ctl.fire) begin
                    acc_next = ctl.last ? '0 : sum;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    acc_reg <= '0;
                end else begin
                    acc_reg <= acc_next;
                end
            end

            always_ff @(posedge aclk) begin
                if (ctl.fire && ctl.last) begin
                    res_reg <= sum;
                end
            end

            assign result[r] = res_reg;
        end else begin : g_absent
            assign result[r] = '0;
        end
    end

endmodule
`default_nettype wire

// ----- design/ternary_weight_gemv_4x64.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ternary_weight_gemv_4x64
// Weight-stationary ternary matrix-vector product: each row's weights are a
// positive and a negative bitmask, activations arrive eight per transfer.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  ---------+-----+--------------------------------------------------------
//  s_axis   | in  | one chunk of eight signed activations
//  m_axis   | out | four signed row sums, one transfer per full vector
//  apb      | in  | row masks, 64 bits each, at byte address 8*index
//
//  One input transfer per cycle, sustained while no final chunk is held. A
//  result reaches m_axis through the lane stage, then the merge register.
//  Reset clears the chunk counter, accumulators, masks and valid flags.
//  Input stalls only while a final chunk waits behind an untaken result;
//  other chunks keep accumulating while a result sits on m_axis.
// ----------------------------------------------------------------------------
module ternary_weight_gemv_4x64
    import twg_pkg::*;
#(
    parameter int VECTOR_LEN = 64,
    parameter int ROW_COUNT  = 4
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // act_0 .. act_7, 8 bits each, act_0 in the lowest bits
    input  wire logic [LANES*ACT_W-1:0]   s_axis_tdata,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // row_result_0 .. row_result_3, 15 bits each from bit 0, zero-padded
    output logic [63:0]                   m_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_AW-1:0]        paddr,
    input  wire logic [CFG_DW-1:0]        pwdata,
    output logic [CFG_DW-1:0]             prdata,
    output logic                          pready
);

    localparam int CHUNKS  = (VECTOR_LEN + LANES - 1) / LANES;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    // ---------------- configuration ----------------
    mask_t pos_mask_reg [MAX_ROWS];
    mask_t neg_mask_reg [MAX_ROWS];
    logic [CFG_AW-4:0] reg_idx;
    logic [CFG_AW-5:0] reg_row;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_AW-1:3];
    assign reg_row = reg_idx[CFG_AW-4:1];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = reg_idx[REG_SEL_NEG] ? neg_mask_reg[reg_row] : pos_mask_reg[reg_row];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < MAX_ROWS; r++) begin
                pos_mask_reg[r] <= '0;
                neg_mask_reg[r] <= '0;
            end
        end else if (cfg_wr) begin
            if (reg_idx[REG_SEL_NEG]) begin
                neg_mask_reg[reg_row] <= pwdata;
            end else begin
                pos_mask_reg[reg_row] <= pwdata;
            end
        end
    end

    // ---------------- handshake and chunk counter ----------------
    logic               out_free;
    logic               s1_adv;
    logic               s_fire;
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_last_reg;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    logic               chunk_last;
    twg_ctl_t           ctl;

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    // a final chunk may only merge once the output register is free
    assign s1_adv        = !s1_valid_reg || !s1_last_reg || out_free;
    assign s_axis_tready = s1_adv;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign chunk_last    = (chunk_reg == CHUNK_W'(CHUNKS - 1));
    assign ctl.fire      = s1_valid_reg && s1_adv;
    assign ctl.last      = s1_last_reg;

    always_comb begin
        s1_valid_next = s1_adv ? s_fire : s1_valid_reg;
        chunk_next    = chunk_reg;
        if (s_fire) begin
            chunk_next = chunk_last ? '0 : chunk_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            chunk_reg    <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            chunk_reg    <= chunk_next;
            if (s_fire) begin
                s1_last_reg <= chunk_last;
            end
        end
    end

    // ---------------- lanes ----------------
    logic [MASK_IW-1:0] mask_base;
    term_t              terms [LANES][MAX_ROWS];

    assign mask_base = MASK_IW'(chunk_reg) << $clog2(LANES);

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [ELEM_W-1:0]   elem;
        logic                active;
        logic [MAX_ROWS-1:0] pos_bits;
        logic [MAX_ROWS-1:0] neg_bits;

        assign elem   = {1'b0, mask_base} + ELEM_W'(l);
        // elements past the vector end contribute nothing
        assign active = (elem < ELEM_W'(VECTOR_LEN));

        always_comb begin
            for (int r = 0; r < MAX_ROWS; r++) begin
                pos_bits[r] = active && (r < ROW_COUNT)
                              && pos_mask_reg[r][mask_base + MASK_IW'(l)];
                neg_bits[r] = active && (r < ROW_COUNT)
                              && neg_mask_reg[r][mask_base + MASK_IW'(l)];
            end
        end

        twg_lane u_lane (
            .aclk     (aclk),
            .load     (s_fire),
            .act      (s_axis_tdata[l*ACT_W +: ACT_W]),
            .pos_bits (pos_bits),
            .neg_bits (neg_bits),
            .term_reg (terms[l])
        );
    end

    // ---------------- merge ----------------
    res_t result [MAX_ROWS];

    twg_merge #(
        .ROW_COUNT (ROW_COUNT)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .terms     (terms),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .result    (result)
    );

    always_comb begin
        m_axis_tdata = '0;
        for (int r = 0; r < MAX_ROWS; r++) begin
            m_axis_tdata[r*RES_W +: RES_W] = result[r];
        end
    end

    // ---------------- assertions ----------------
    a_stall_only_on_full_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && s1_valid_reg && s1_last_reg))
        else $error("input stalled without a blocked final chunk");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.fire && ctl.last) |=> m_axis_tvalid)
        else $error("final chunk merged but no result presented");

    a_reset_clears_chunk: assert property (@(posedge aclk)
        !aresetn |=> (chunk_reg == '0 && !s1_valid_reg && !m_axis_tvalid))
        else $error("reset left the chunk counter or valids set");

    a_last_flag_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (s1_last_reg == (chunk_reg == '0)))
        else $error("final-chunk flag out of step with chunk counter");

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams activation chunks into the ternary matrix-vector block and checks
// every row-sum transfer against a cycle-free model of the masked dot
// products. Row masks are reprogrammed between phases, also while a vector is open.
// ----------------------------------------------------------------------------
module testbench;
    import twg_pkg::*;

    localparam int CHUNKS        = 64 / LANES;
    localparam int RANDOM_ITEMS  = 1026;
    localparam int LONG_HOLD     = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 100000;

    typedef enum int {
        POS_MASK_ROW0, NEG_MASK_ROW0, POS_MASK_ROW1, NEG_MASK_ROW1,
        POS_MASK_ROW2, NEG_MASK_ROW2, POS_MASK_ROW3, NEG_MASK_ROW3
    } mask_reg_t;

    typedef logic [MAX_ROWS-1:0][RES_W-1:0] row_sums_t;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic [LANES*ACT_W-1:0] s_axis_tdata  = '0;  // act_0 .. act_7, 8 bits each
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [63:0]            m_axis_tdata;        // row_result_0 .. 3, 15 bits each
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [CFG_AW-1:0]      paddr         = '0;
    logic [CFG_DW-1:0]      pwdata        = '0;
    logic [CFG_DW-1:0]      prdata;
    logic                   pready;

    ternary_weight_gemv_4x64 u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Shared between the sequence and the bus processes
    logic [LANES*ACT_W-1:0] act_chunk_q[$];
    row_sums_t              row_sums_q[$];
    bit                     idle_on       = 1'b0;
    int unsigned            hold_requests = 0;
    int unsigned            mismatch_count = 0;
    int unsigned            cycle_count   = 0;

    // Weight masks and partial sums as the block should hold them
    mask_t pos_w[MAX_ROWS];
    mask_t neg_w[MAX_ROWS];
    int    row_acc[MAX_ROWS];
    int    chunk_idx;

    initial begin
        for (int r = 0; r < MAX_ROWS; r++) begin
            pos_w[r]   = '0;
            neg_w[r]   = '0;
            row_acc[r] = 0;
        end
        chunk_idx = 0;
    end

    function automatic void fold_chunk(logic [LANES*ACT_W-1:0] data);
        int        elem;
        act_t      a;
        row_sums_t sums;
        for (int r = 0; r < MAX_ROWS; r++) begin
            for (int l = 0; l < LANES; l++) begin
                elem = chunk_idx * LANES + l;
                a    = data[ACT_W*l +: ACT_W];
                // both bits set leaves the weight at zero
                if (pos_w[r][elem] && !neg_w[r][elem])
                    row_acc[r] += a;
                else if (neg_w[r][elem] && !pos_w[r][elem])
                    row_acc[r] -= a;
            end
        end
        chunk_idx++;
        if (chunk_idx == CHUNKS) begin
            for (int r = 0; r < MAX_ROWS; r++) begin
                sums[r]    = row_acc[r][RES_W-1:0];
                row_acc[r] = 0;
            end
            row_sums_q.push_back(sums);
            chunk_idx = 0;
        end
    endfunction

    function automatic void check_row_sums(logic [63:0] data);
        row_sums_t want;
        res_t      got;
        if (row_sums_q.size() == 0) begin
            $display("%0t ns: result %h with none expected", $time, data);
            mismatch_count++;
            return;
        end
        want = row_sums_q.pop_front();
        for (int r = 0; r < MAX_ROWS; r++) begin
            got = data[RES_W*r +: RES_W];
            if (got !== res_t'(want[r])) begin
                $display("%0t ns: row_result_%0d expected %0d, got %0d",
                         $time, r, res_t'(want[r]), got);
                mismatch_count++;
            end
        end
    endfunction

    // Source: present queued chunks, fold each one in as it transfers
    int unsigned src_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                fold_chunk(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 2);
                    s_axis_tvalid <= 1'b0;
                end else if (act_chunk_q.size() > 0) begin
                    s_axis_tdata  <= act_chunk_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink: check each transfer, stall in short bursts or one long hold
    int unsigned sink_stall = 0;
    int unsigned sink_hold  = 0;
    int unsigned hold_seen  = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_row_sums(m_axis_tdata);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                sink_hold = LONG_HOLD;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                sink_stall = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_mask(mask_reg_t idx, mask_t value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(8 * idx);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx % 2)
            neg_w[idx / 2] = value;
        else
            pos_w[idx / 2] = value;
    endtask

    task automatic set_row(int row, mask_t pos, mask_t neg);
        write_mask(mask_reg_t'(2 * row), pos);
        write_mask(mask_reg_t'(2 * row + 1), neg);
    endtask

    // Drain both channels, then let the pipeline empty out
    task automatic settle();
        do @(negedge aclk);
        while (act_chunk_q.size() != 0 || s_axis_tvalid || row_sums_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic act_t pick_act(bit edgy);
        if (edgy) begin
            case ($urandom_range(0, 3))
                0:       return act_t'(-128);
                1:       return act_t'(127);
                2:       return act_t'(0);
                default: return act_t'(-1);
            endcase
        end
        return act_t'($urandom_range(0, 255));
    endfunction

    function automatic mask_t pick_mask();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        logic [LANES*ACT_W-1:0] chunk;
        int unsigned            sent;
        int unsigned            n;
        int unsigned            phase;
        bit                     edgy;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Full positive row, full negative row, both-bits row, alternating row
        set_row(0, '1, '0);
        set_row(1, '0, '1);
        set_row(2, '1, '1);
        set_row(3, {32{2'b01}}, {32{2'b10}});
        @(negedge aclk);
        repeat (CHUNKS) act_chunk_q.push_back({LANES{8'h80}});
        repeat (CHUNKS) act_chunk_q.push_back({LANES{8'h7f}});
        repeat (CHUNKS / 2) act_chunk_q.push_back({4{8'h7f, 8'h80}});
        settle();

        // New masks take effect from the next chunk of the open vector
        set_row(0, {32{2'b10}}, {32{2'b11}});
        set_row(1, {$urandom, $urandom}, '0);
        @(negedge aclk);
        repeat (CHUNKS / 2) act_chunk_q.push_back({4{8'h00, 8'hff}});
        settle();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            for (int r = 0; r < MAX_ROWS; r++)
                set_row(r, pick_mask(), pick_mask());
            n = $urandom_range(60, 140);
            @(negedge aclk);
            // quiet handshakes over the final stretch
            idle_on = (sent + n + 200 < RANDOM_ITEMS) && ($urandom_range(0, 3) != 0);
            if (phase == 1)
                hold_requests++;
            for (int i = 0; i < n; i++) begin
                if (i % CHUNKS == 0)
                    edgy = ($urandom_range(0, 4) == 0);
                for (int l = 0; l < LANES; l++)
                    chunk[ACT_W*l +: ACT_W] = pick_act(edgy && $urandom_range(0, 1));
                act_chunk_q.push_back(chunk);
            end
            sent += n;
            phase++;
            settle();
        end

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
